[rtl/core/mbe_pkg.sv]
// shared types and constants for the mask boundary edge extractor
`default_nettype none
package mbe_pkg;

	localparam int COORD_W = 13;
	localparam int PIX_W = 8;
	localparam int KIND_W = 2;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_ADDR_W = 3;
	localparam int DEF_MAX_WIDTH = 4096;
	localparam int DEF_MAX_HEIGHT = 4096;

	typedef logic [COORD_W-1:0] coord_t;

	localparam coord_t DIM_RESET = 13'd256;

	typedef enum logic [KIND_W-1:0] {
		KIND_VERT    = 2'd0,
		KIND_HORIZ   = 2'd1,
		KIND_SUMMARY = 2'd2
	} kind_t;

	typedef enum logic {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		coord_t width;
		coord_t height;
	} dims_t;

	// one scanned lattice position on its way to the emit stage
	typedef struct packed {
		coord_t x;
		coord_t y;
		logic   cur;
		logic   left;
		logic   top_need;
		logic   last_pos;
	} item_t;

endpackage
`default_nettype wire

[rtl/core/mbe_pixel_if.sv]
// pixel stream channel: valid, ready and the mask value
`default_nettype none
interface mbe_pixel_if;
	import mbe_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_value;

	modport source(output valid, output pixel_value, input ready);
	modport sink(input valid, input pixel_value, output ready);
endinterface
`default_nettype wire

[rtl/core/mbe_result_if.sv]
// result channel: segments and frame summaries
`default_nettype none
interface mbe_result_if;
	import mbe_pkg::*;

	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] result_kind;
	coord_t            seg_x;
	coord_t            seg_y;
	coord_t            box_min_x;
	coord_t            box_min_y;
	coord_t            box_max_x;
	coord_t            box_max_y;
	logic              last_of_item;

	modport source(
		output valid, output result_kind, output seg_x, output seg_y,
		output box_min_x, output box_min_y, output box_max_x, output box_max_y,
		output last_of_item, input ready
	);
	modport sink(
		input valid, input result_kind, input seg_x, input seg_y,
		input box_min_x, input box_min_y, input box_max_x, input box_max_y,
		input last_of_item, output ready
	);
endinterface
`default_nettype wire

[rtl/core/mask_boundary_edge_extractor.sv]
// Mask boundary edge extractor: boundary segments and bounding box of a raster mask.
// Pipeline: a position passes the stage-one item register and then the output register.
// Throughput: one position per cycle while results are taken; the single output register
// sends one result per cycle; a position with several results holds the input till all load.
// Line store: one-bit read-first memory of MAX_WIDTH entries, one access per position.
// Reset: counters, box, handshakes cleared; dims min(256, limit); line store not cleared.
`default_nettype none
module mask_boundary_edge_extractor #(
	parameter int MAX_WIDTH  = mbe_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = mbe_pkg::DEF_MAX_HEIGHT
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [mbe_pkg::CFG_ADDR_W-1:0]  paddr,
	input  wire logic [mbe_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic      [mbe_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                                 pready,
	mbe_pixel_if.sink                            pixels,
	mbe_result_if.source                         results
);
	import mbe_pkg::*;

	dims_t dims;
	item_t item_s1;
	logic  item_valid_s1;
	logic  top_rd_s1;
	logic  retire;

	mbe_cfg #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.dims   (dims)
	);

	mbe_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.dims         (dims),
		.pixels       (pixels),
		.retire       (retire),
		.item_valid_s1(item_valid_s1),
		.item_s1      (item_s1),
		.top_rd_s1    (top_rd_s1)
	);

	mbe_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid_s1(item_valid_s1),
		.item_s1      (item_s1),
		.top_rd_s1    (top_rd_s1),
		.retire       (retire),
		.results      (results)
	);

endmodule
`default_nettype wire

[rtl/core/mbe_cfg.sv]
// apb register file holding the clamped image width and height
`default_nettype none
module mbe_cfg #(
	parameter int MAX_WIDTH  = mbe_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = mbe_pkg::DEF_MAX_HEIGHT
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [mbe_pkg::CFG_ADDR_W-1:0]  paddr,
	input  wire logic [mbe_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic      [mbe_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                                 pready,
	output mbe_pkg::dims_t                       dims
);
	import mbe_pkg::*;

	localparam coord_t W_LIMIT = (MAX_WIDTH >= 8191) ? 13'h1FFF : COORD_W'(MAX_WIDTH);
	localparam coord_t H_LIMIT = (MAX_HEIGHT >= 8191) ? 13'h1FFF : COORD_W'(MAX_HEIGHT);
	localparam coord_t W_RESET = (DIM_RESET > W_LIMIT) ? W_LIMIT : DIM_RESET;
	localparam coord_t H_RESET = (DIM_RESET > H_LIMIT) ? H_LIMIT : DIM_RESET;

	function automatic coord_t clamp_dim(input coord_t d, input coord_t lim);
		return (d == '0) ? coord_t'(1) : ((d > lim) ? lim : d);
	endfunction

	coord_t   width_q;
	coord_t   height_q;
	logic     wr;
	reg_idx_t idx;

	assign wr     = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[2]);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= W_RESET;
			height_q <= H_RESET;
		end else if (wr) begin
			case (idx)
				REG_WIDTH: begin
					width_q <= clamp_dim(pwdata[COORD_W-1:0], W_LIMIT);
				end
				REG_HEIGHT: begin
					height_q <= clamp_dim(pwdata[COORD_W-1:0], H_LIMIT);
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_WIDTH:  prdata = CFG_DATA_W'(width_q);
			REG_HEIGHT: prdata = CFG_DATA_W'(height_q);
			default:    prdata = '0;
		endcase
	end

	assign dims.width  = width_q;
	assign dims.height = height_q;

endmodule
`default_nettype wire

[rtl/core/mbe_front.sv]
// raster position tracking, line store read-modify-write and first pipeline stage
`default_nettype none
module mbe_front #(
	parameter int MAX_WIDTH = mbe_pkg::DEF_MAX_WIDTH
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire mbe_pkg::dims_t dims,
	mbe_pixel_if.sink           pixels,
	input  wire logic           retire,
	output logic                item_valid_s1,
	output mbe_pkg::item_t      item_s1,
	output logic                top_rd_s1
);
	import mbe_pkg::*;

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	// set-ness of the row above, one bit per column
	logic row_mem [MAX_WIDTH];

	coord_t col_q;
	coord_t row_q;
	logic   left_q;
	logic   in_col;
	logic   in_row;
	logic   cur;
	logic   last_pos;
	logic   fire;

	assign pixels.ready = !item_valid_s1 || retire;
	assign fire         = pixels.valid && pixels.ready;

	assign in_col   = col_q < dims.width;
	assign in_row   = row_q < dims.height;
	assign cur      = in_col && in_row && (pixels.pixel_value != '0);
	assign last_pos = !in_col && !in_row;

	// read-first: each position reads its column's old bit; positions inside the width write the new one
	always_ff @(posedge clk) begin
		if (fire) begin
			top_rd_s1 <= row_mem[AW'(col_q)];
			if (in_col) begin
				row_mem[AW'(col_q)] <= cur;
			end
			item_s1.x        <= col_q;
			item_s1.y        <= row_q;
			item_s1.cur      <= cur;
			item_s1.left     <= (col_q != '0) && left_q;
			item_s1.top_need <= (row_q != '0) && in_col;
			item_s1.last_pos <= last_pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q         <= '0;
			row_q         <= '0;
			left_q        <= 1'b0;
			item_valid_s1 <= 1'b0;
		end else begin
			if (fire) begin
				left_q <= cur && !last_pos;
				if (last_pos) begin
					col_q <= '0;
					row_q <= '0;
				end else if (!in_col) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
			if (fire) begin
				item_valid_s1 <= 1'b1;
			end else if (retire) begin
				item_valid_s1 <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		fire && last_pos |=> (col_q == '0) && (row_q == '0) && !left_q)
		else $error("scan position not restarted after frame end");
`endif

endmodule
`default_nettype wire

[rtl/core/mbe_emit.sv]
// segment detection, bounding box tracking and the output register
`default_nettype none
module mbe_emit (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           item_valid_s1,
	input  wire mbe_pkg::item_t item_s1,
	input  wire logic           top_rd_s1,
	output logic                retire,
	mbe_result_if.source        results
);
	import mbe_pkg::*;

	// bit 0 vertical, bit 1 horizontal, bit 2 summary
	logic [2:0] want;
	logic [2:0] done_q;
	logic [2:0] pend;
	logic [2:0] pick;
	logic       top;
	logic       out_free;
	logic       load;
	logic       pick_last;
	logic       seg;

	coord_t min_x_q, min_y_q, max_x_q, max_y_q;
	logic   any_q;
	coord_t min_x_n, min_y_n, max_x_n, max_y_n;
	coord_t seg_max_x, seg_max_y;
	logic   any_n;

	logic              out_valid_q;
	logic [KIND_W-1:0] kind_q;
	coord_t            seg_x_q, seg_y_q;
	coord_t            bmin_x_q, bmin_y_q, bmax_x_q, bmax_y_q;
	logic              last_q;
	kind_t             kind_n;

	assign top  = item_s1.top_need && top_rd_s1;
	assign want = {item_s1.last_pos, top != item_s1.cur, item_s1.left != item_s1.cur};
	assign pend = want & ~done_q;
	assign pick = pend & (~pend + 3'd1);

	assign out_free  = !out_valid_q || results.ready;
	assign load      = item_valid_s1 && (pend != '0) && out_free;
	assign pick_last = (pend & ~pick) == '0;
	assign retire    = item_valid_s1 && ((pend == '0) || (load && pick_last));

	// box after this position's segments
	assign seg       = want[0] || want[1];
	assign seg_max_x = want[1] ? item_s1.x + 1'b1 : item_s1.x;
	assign seg_max_y = want[0] ? item_s1.y + 1'b1 : item_s1.y;
	assign any_n     = any_q || seg;

	always_comb begin
		min_x_n = min_x_q;
		min_y_n = min_y_q;
		max_x_n = max_x_q;
		max_y_n = max_y_q;
		if (seg) begin
			min_x_n = (any_q && (min_x_q < item_s1.x)) ? min_x_q : item_s1.x;
			min_y_n = (any_q && (min_y_q < item_s1.y)) ? min_y_q : item_s1.y;
			max_x_n = (any_q && (max_x_q > seg_max_x)) ? max_x_q : seg_max_x;
			max_y_n = (any_q && (max_y_q > seg_max_y)) ? max_y_q : seg_max_y;
		end
	end

	always_comb begin
		if (pick[0]) begin
			kind_n = KIND_VERT;
		end else if (pick[1]) begin
			kind_n = KIND_HORIZ;
		end else begin
			kind_n = KIND_SUMMARY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q  <= '0;
			any_q   <= 1'b0;
			min_x_q <= '0;
			min_y_q <= '0;
			max_x_q <= '0;
			max_y_q <= '0;
		end else begin
			if (retire) begin
				done_q <= '0;
			end else if (load) begin
				done_q <= done_q | pick;
			end
			if (retire) begin
				if (item_s1.last_pos) begin
					any_q   <= 1'b0;
					min_x_q <= '0;
					min_y_q <= '0;
					max_x_q <= '0;
					max_y_q <= '0;
				end else if (seg) begin
					any_q   <= 1'b1;
					min_x_q <= min_x_n;
					min_y_q <= min_y_n;
					max_x_q <= max_x_n;
					max_y_q <= max_y_n;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q   <= kind_n;
			seg_x_q  <= pick[2] ? '0 : item_s1.x;
			seg_y_q  <= pick[2] ? '0 : item_s1.y;
			bmin_x_q <= (pick[2] && any_n) ? min_x_n : '0;
			bmin_y_q <= (pick[2] && any_n) ? min_y_n : '0;
			bmax_x_q <= (pick[2] && any_n) ? max_x_n : '0;
			bmax_y_q <= (pick[2] && any_n) ? max_y_n : '0;
			last_q   <= pick_last;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.result_kind  = kind_q;
	assign results.seg_x        = seg_x_q;
	assign results.seg_y        = seg_y_q;
	assign results.box_min_x    = bmin_x_q;
	assign results.box_min_y    = bmin_y_q;
	assign results.box_max_x    = bmax_x_q;
	assign results.box_max_y    = bmax_y_q;
	assign results.last_of_item = last_q;

`ifndef SYNTHESIS
	a_box_order: assert property (@(posedge clk) disable iff (!arst_n)
		any_q |-> (min_x_q <= max_x_q) && (min_y_q <= max_y_q))
		else $error("bounding box min above max");

	a_box_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!any_q |-> (min_x_q == '0) && (min_y_q == '0) && (max_x_q == '0) && (max_y_q == '0))
		else $error("bounding box not cleared without segments");

	a_summary_last: assert property (@(posedge clk) disable iff (!arst_n)
		load && pick[2] |=> results.valid && results.last_of_item
			&& (results.result_kind == KIND_SUMMARY))
		else $error("frame summary not sent as last result of its position");
`endif

endmodule
`default_nettype wire
